// ===== hdl/tree_ensemble_inference_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef TREE_ENSEMBLE_INFERENCE_MACROS_SVH
`define TREE_ENSEMBLE_INFERENCE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TEI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TEI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== hdl/tei_pkg.sv =====
package tei_pkg;

   // Default sizing of the stores
   localparam int DEF_NUM_TREES     = 16;
   localparam int DEF_DEEPEST_LEVEL = 8;
   localparam int DEF_NUM_FEATURES  = 256;

   // Field widths
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 36;
   localparam int TREE_NUM_W  = 4;
   localparam int NODE_IDX_W  = 9;
   localparam int FEAT_IDX_W  = 8;
   localparam int LEAF_ID_W   = 16;
   localparam int TREES_CFG_W = 5;
   localparam int DEPTH_CFG_W = 4;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TREES_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_LIMIT  = 1'd1;

   // Reset values of the registers
   localparam logic [TREES_CFG_W-1:0] TREES_RESET = 5'd16;
   localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = 4'd8;

   // Node entry layout: leaf flag, feature, threshold
   localparam int SPLIT_W   = 1 + FEAT_IDX_W + VALUE_W;
   localparam int LEAF_W    = LEAF_ID_W + VALUE_W;
   localparam int LEAF_FLAG = SPLIT_W - 1;

   // Failed walk result
   localparam logic [LEAF_ID_W-1:0] FAIL_ID       = 16'hFFFF;
   localparam logic [VALUE_W-1:0]   MINUS_ONE_Q16 = 32'hFFFF_0000;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_SPLIT,
      CMD_LEAF,
      CMD_FEATURE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [TREE_NUM_W-1:0]  tree;
      logic [NODE_IDX_W-1:0]  node;
      logic [FEAT_IDX_W-1:0]  sel;      // split feature or query feature index
      logic [VALUE_W-1:0]     value;    // threshold, leaf value or feature value
      logic [LEAF_ID_W-1:0]   leaf_id;
      logic                   start;    // walk all trees after this command
   } cmd_type;

   typedef struct packed {
      logic [TREES_CFG_W-1:0] trees_in_use;
      logic [DEPTH_CFG_W-1:0] depth_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_FETCH,
      B_DECIDE,
      B_COMPARE,
      B_EMIT
   } back_state_type;

endpackage

// ===== hdl/tei_front.sv =====
module tei_front #(
   parameter int NUM_TREES     = tei_pkg::DEF_NUM_TREES,
   parameter int DEEPEST_LEVEL = tei_pkg::DEF_DEEPEST_LEVEL,
   parameter int NUM_FEATURES  = tei_pkg::DEF_NUM_FEATURES
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tei_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            queue_full,
   output logic                            push,
   output tei_pkg::cmd_type                push_cmd
);
   import tei_pkg::*;

   localparam int NODES_PER_TREE = 1 << (DEEPEST_LEVEL + 1);
   localparam int FEAT_N = (NUM_FEATURES < (1 << FEAT_IDX_W)) ? NUM_FEATURES
                                                              : (1 << FEAT_IDX_W);

   logic [TREE_NUM_W-1:0] f_tree;
   logic [NODE_IDX_W-1:0] f_node;
   logic                  f_is_leaf;
   logic [FEAT_IDX_W-1:0] f_split_feature;
   logic [VALUE_W-1:0]    f_threshold;
   logic [VALUE_W-1:0]    f_leaf_value;
   logic [LEAF_ID_W-1:0]  f_leaf_number;
   logic [FEAT_IDX_W-1:0] f_feature_index;
   logic [VALUE_W-1:0]    f_feature_value;
   logic                  f_present;

   // Unpack the request fields
   assign f_tree          = req_tdata[3:0];
   assign f_node          = req_tdata[12:4];
   assign f_is_leaf       = req_tdata[13];
   assign f_split_feature = req_tdata[21:14];
   assign f_threshold     = req_tdata[53:22];
   assign f_leaf_value    = req_tdata[85:54];
   assign f_leaf_number   = req_tdata[101:86];
   assign f_feature_index = req_tdata[109:102];
   assign f_feature_value = req_tdata[141:110];
   assign f_present       = req_tdata[142];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Classify: out-of-store loads/writes, absent features become no-ops
   always_comb begin
      push_cmd.kind    = CMD_NONE;
      push_cmd.tree    = f_tree;
      push_cmd.node    = f_node;
      push_cmd.sel     = f_split_feature;
      push_cmd.value   = f_threshold;
      push_cmd.leaf_id = f_leaf_number;
      push_cmd.start   = 1'b0;
      if (!req_tuser) begin
         if ((int'(f_tree) < NUM_TREES) && (int'(f_node) < NODES_PER_TREE)) begin
            if (f_is_leaf) begin
               push_cmd.kind  = CMD_LEAF;
               push_cmd.value = f_leaf_value;
            end else begin
               push_cmd.kind = CMD_SPLIT;
            end
         end
      end else begin
         push_cmd.sel   = f_feature_index;
         push_cmd.value = f_feature_value;
         push_cmd.start = req_tlast;
         if (f_present && (int'(f_feature_index) < FEAT_N)) begin
            push_cmd.kind = CMD_FEATURE;
         end
      end
   end

endmodule

// ===== hdl/tei_queue.sv =====
module tei_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tei_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output tei_pkg::cmd_type pop_cmd
);
   import tei_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/tei_back.sv =====
module tei_back #(
   parameter int NUM_TREES     = tei_pkg::DEF_NUM_TREES,
   parameter int DEEPEST_LEVEL = tei_pkg::DEF_DEEPEST_LEVEL,
   parameter int NUM_FEATURES  = tei_pkg::DEF_NUM_FEATURES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tei_pkg::cfg_type                cfg,
   input  logic                            q_valid,
   input  tei_pkg::cmd_type                q_cmd,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tei_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import tei_pkg::*;

   localparam int TREE_W  = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
   localparam int NT_W    = $clog2(NUM_TREES + 1);
   localparam int NODE_W  = DEEPEST_LEVEL + 1;
   localparam int DEPTH_W = $clog2(DEEPEST_LEVEL + 1);
   localparam int MEM_N   = NUM_TREES << NODE_W;
   localparam int ADDR_W  = $clog2(MEM_N);
   localparam int FEAT_N  = (NUM_FEATURES < (1 << FEAT_IDX_W)) ? NUM_FEATURES
                                                               : (1 << FEAT_IDX_W);
   localparam int FEAT_W  = $clog2(FEAT_N);

   // Node and feature stores
   logic [SPLIT_W-1:0] split_mem [MEM_N];
   logic [LEAF_W-1:0]  leaf_mem  [MEM_N];
   logic [VALUE_W-1:0] feat_mem  [FEAT_N];
   logic [FEAT_N-1:0]  seen_ff;

   logic [SPLIT_W-1:0] split_rd_ff;
   logic [LEAF_W-1:0]  leaf_rd_ff;
   logic [VALUE_W-1:0] feat_rd_ff;
   logic               seen_rd_ff;

   back_state_type     state_ff, state_in;
   logic [TREE_W-1:0]  tree_ff, tree_in;
   logic [NT_W-1:0]    nt_ff, nt_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [DEPTH_W-1:0] lim_ff, lim_in;
   logic [LEAF_ID_W-1:0] res_id_ff, res_id_in;
   logic [VALUE_W-1:0] res_val_ff, res_val_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TREE_NUM_W-1:0] out_tree_ff, out_tree_in;
   logic [LEAF_ID_W-1:0]  out_id_ff, out_id_in;
   logic [VALUE_W-1:0]    out_val_ff, out_val_in;
   logic [SUM_W-1:0]      out_sum_ff, out_sum_in;
   logic                  out_last_ff, out_last_in;

   logic [NT_W-1:0]    nt_clamp;
   logic [DEPTH_W-1:0] lim_clamp;
   logic               wr_node;
   logic               wr_leaf;
   logic               wr_feat;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [SPLIT_W-1:0] split_wdata;
   logic [FEAT_IDX_W-1:0] rd_feature;
   logic [FEAT_W-1:0]  rd_faddr;
   logic               rd_f_in_range;
   logic               go_right;
   logic               last_tree;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_next;
   logic               seen_clear;

   // Register values limited to what the stores hold
   always_comb begin
      if (cfg.trees_in_use == '0) begin
         nt_clamp = NT_W'(1);
      end else if (int'(cfg.trees_in_use) > NUM_TREES) begin
         nt_clamp = NT_W'(NUM_TREES);
      end else begin
         nt_clamp = NT_W'(cfg.trees_in_use);
      end
      if (int'(cfg.depth_limit) > DEEPEST_LEVEL) begin
         lim_clamp = DEPTH_W'(DEEPEST_LEVEL);
      end else begin
         lim_clamp = DEPTH_W'(cfg.depth_limit);
      end
   end

   // Store writes from the queue
   assign wr_node     = pop && ((q_cmd.kind == CMD_SPLIT) || (q_cmd.kind == CMD_LEAF));
   assign wr_leaf     = pop && (q_cmd.kind == CMD_LEAF);
   assign wr_feat     = pop && (q_cmd.kind == CMD_FEATURE);
   assign wr_addr     = ADDR_W'({TREE_W'(q_cmd.tree), NODE_W'(q_cmd.node)});
   assign split_wdata = (q_cmd.kind == CMD_LEAF) ? {1'b1, {(SPLIT_W-1){1'b0}}}
                                                 : {1'b0, q_cmd.sel, q_cmd.value};

   // Walk read addresses
   assign rd_addr       = ADDR_W'({tree_ff, node_ff});
   assign rd_feature    = split_rd_ff[VALUE_W +: FEAT_IDX_W];
   assign rd_faddr      = rd_feature[FEAT_W-1:0];
   assign rd_f_in_range = (int'(rd_feature) < FEAT_N);

   // Absent feature or value below threshold goes left
   assign go_right  = seen_rd_ff &&
                      !($signed(feat_rd_ff) < $signed(split_rd_ff[VALUE_W-1:0]));
   assign last_tree = ((NT_W'(tree_ff) + NT_W'(1)) == nt_ff);

   // Saturating running sum
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} +
                     {{(SUM_W+1-VALUE_W){res_val_ff[VALUE_W-1]}}, res_val_ff};
   assign sum_next = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                     ? {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}}
                     : sum_wide[SUM_W-1:0];

   // Sequencer: one command per cycle in idle; fetch/decide/compare per level
   always_comb begin
      state_in     = state_ff;
      tree_in      = tree_ff;
      nt_in        = nt_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      lim_in       = lim_ff;
      res_id_in    = res_id_ff;
      res_val_in   = res_val_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_tree_in  = out_tree_ff;
      out_id_in    = out_id_ff;
      out_val_in   = out_val_ff;
      out_sum_in   = out_sum_ff;
      out_last_in  = out_last_ff;
      seen_clear   = 1'b0;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               if (q_cmd.start) begin
                  tree_in  = '0;
                  nt_in    = nt_clamp;
                  lim_in   = lim_clamp;
                  node_in  = NODE_W'(1);
                  depth_in = '0;
                  sum_in   = '0;
                  state_in = B_FETCH;
               end
            end
         end
         B_FETCH: begin
            state_in = B_DECIDE;
         end
         B_DECIDE: begin
            if (split_rd_ff[LEAF_FLAG]) begin
               res_id_in  = leaf_rd_ff[VALUE_W +: LEAF_ID_W];
               res_val_in = leaf_rd_ff[VALUE_W-1:0];
               state_in   = B_EMIT;
            end else begin
               state_in = B_COMPARE;
            end
         end
         B_COMPARE: begin
            if (depth_ff == lim_ff) begin
               res_id_in  = FAIL_ID;
               res_val_in = MINUS_ONE_Q16;
               state_in   = B_EMIT;
            end else begin
               node_in  = {node_ff[NODE_W-2:0], go_right};
               depth_in = depth_ff + DEPTH_W'(1);
               state_in = B_FETCH;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_tree_in  = TREE_NUM_W'(tree_ff);
               out_id_in    = res_id_ff;
               out_val_in   = res_val_ff;
               out_sum_in   = sum_next;
               out_last_in  = last_tree;
               sum_in       = sum_next;
               if (last_tree) begin
                  seen_clear = 1'b1;
                  state_in   = B_IDLE;
               end else begin
                  tree_in  = tree_ff + TREE_W'(1);
                  node_in  = NODE_W'(1);
                  depth_in = '0;
                  state_in = B_FETCH;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and output payload
   always_ff @(posedge clock) begin
      tree_ff     <= tree_in;
      nt_ff       <= nt_in;
      node_ff     <= node_in;
      depth_ff    <= depth_in;
      lim_ff      <= lim_in;
      res_id_ff   <= res_id_in;
      res_val_ff  <= res_val_in;
      sum_ff      <= sum_in;
      out_tree_ff <= out_tree_in;
      out_id_ff   <= out_id_in;
      out_val_ff  <= out_val_in;
      out_sum_ff  <= out_sum_in;
      out_last_ff <= out_last_in;
   end

   // Node stores: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_node) begin
         split_mem[wr_addr] <= split_wdata;
      end
      if (wr_leaf) begin
         leaf_mem[wr_addr] <= {q_cmd.leaf_id, q_cmd.value};
      end
      split_rd_ff <= split_mem[rd_addr];
      leaf_rd_ff  <= leaf_mem[rd_addr];
   end

   // Feature values
   always_ff @(posedge clock) begin
      if (wr_feat) begin
         feat_mem[q_cmd.sel[FEAT_W-1:0]] <= q_cmd.value;
      end
      feat_rd_ff <= feat_mem[rd_faddr];
   end

   // Presence bits, cleared when a query finishes
   always_ff @(posedge clock) begin
      if (reset || seen_clear) begin
         seen_ff <= '0;
      end else if (wr_feat) begin
         seen_ff[q_cmd.sel[FEAT_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      seen_rd_ff <= rd_f_in_range && seen_ff[rd_faddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_sum_ff, out_val_ff, out_id_ff, out_tree_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hdl/tree_ensemble_inference.sv =====
// Decision tree ensemble inference, values in signed Q16.16.
// req_* stream: tuser selects the item kind (0 node load, 1 query feature);
// tlast on a feature item ends the query and starts the tree walks.
// Node loads and feature writes are taken one per cycle into a four-entry
// command queue; req_tready drops only while that queue is full.
// The back end executes one queued command per cycle while no walk runs.
// A query walks trees 0 .. trees_in_use-1 in turn: each split level steps
// through a node store read, a feature store read and a compare; a tree
// that ends at a leaf needs no compare at the leaf level before its result
// is posted; a walk that meets a split at depth_limit fails. The walk of
// tree 0 begins when the last feature item is taken from the queue.
// rsp_* stream: one result per tree, tlast on the final tree. The result
// register holds while rsp_tready is low and the walk waits on it; the
// front end keeps filling the queue meanwhile.
// csr_* port: register writes, always ready; write only while idle.
// Reset (synchronous) empties the queue, clears presence bits and restores
// trees_in_use 16 and depth_limit 8; node and feature stores are not cleared.
module tree_ensemble_inference #(
   parameter int NUM_TREES     = tei_pkg::DEF_NUM_TREES,
   parameter int DEEPEST_LEVEL = tei_pkg::DEF_DEEPEST_LEVEL,
   parameter int NUM_FEATURES  = tei_pkg::DEF_NUM_FEATURES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tree_number, node_index, node_is_leaf, split_feature, split_threshold,
   // leaf_value, leaf_number, feature_index, feature_value, feature_present, pad
   input  logic [tei_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tree_index, reached_leaf, tree_value, forest_sum
   output logic [tei_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tei_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tei_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tei_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    q_valid;
   cmd_type q_cmd;
   logic    pop;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TREES_IN_USE: cfg_in.trees_in_use = csr_data[TREES_CFG_W-1:0];
            CSR_DEPTH_LIMIT:  cfg_in.depth_limit  = csr_data[DEPTH_CFG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trees_in_use <= TREES_RESET;
         cfg_ff.depth_limit  <= DEPTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tei_front #(
      .NUM_TREES     (NUM_TREES),
      .DEEPEST_LEVEL (DEEPEST_LEVEL),
      .NUM_FEATURES  (NUM_FEATURES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tei_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .valid    (q_valid),
      .pop_cmd  (q_cmd)
   );

   tei_back #(
      .NUM_TREES     (NUM_TREES),
      .DEEPEST_LEVEL (DEEPEST_LEVEL),
      .NUM_FEATURES  (NUM_FEATURES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/tei_checker.sv =====
`include "tree_ensemble_inference_macros.svh"

module tei_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tei_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import tei_pkg::*;

   logic                  first_tree;
   logic                  sum_is_value;
   logic                  stalled;

   // First tree of a query: running sum equals its own value
   assign first_tree   = rsp_tvalid && (rsp_tdata[3:0] == '0);
   assign sum_is_value = ($signed(rsp_tdata[87:52]) == $signed(rsp_tdata[51:20]));
   assign stalled      = rsp_tvalid && !rsp_tready;

   // A stalled result stays offered and unchanged
   `TEI_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `TEI_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)
   `TEI_ASSERT_IMPL(a_first_sum, clock, reset, first_tree, sum_is_value)

endmodule

bind tree_ensemble_inference tei_checker u_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tei_pkg::*;

   localparam int NUM_TREES     = DEF_NUM_TREES;
   localparam int DEEPEST_LEVEL = DEF_DEEPEST_LEVEL;
   localparam int NUM_FEATURES  = DEF_NUM_FEATURES;
   localparam int NODE_SLOTS    = 1 << (DEEPEST_LEVEL + 1);

   localparam logic MODE_NODE    = 1'b0;
   localparam logic MODE_FEATURE = 1'b1;

   localparam longint SUM_MAX = (longint'(1) << (SUM_W - 1)) - 1;
   localparam longint SUM_MIN = -(longint'(1) << (SUM_W - 1));

   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;

   // one stream item, every field of the request
   typedef struct {
      logic                  mode;
      logic [TREE_NUM_W-1:0] tree;
      logic [NODE_IDX_W-1:0] node;
      logic                  is_leaf;
      logic [FEAT_IDX_W-1:0] split_feature;
      logic [VALUE_W-1:0]    split_threshold;
      logic [VALUE_W-1:0]    leaf_value;
      logic [LEAF_ID_W-1:0]  leaf_id;
      logic [FEAT_IDX_W-1:0] feature_index;
      logic [VALUE_W-1:0]    feature_value;
      logic                  present;
      logic                  last;
   } forest_item_type;

   // one per-tree result of a query
   typedef struct packed {
      logic [TREE_NUM_W-1:0] tree;
      logic [LEAF_ID_W-1:0]  leaf_id;
      logic [VALUE_W-1:0]    value;
      logic [SUM_W-1:0]      sum;
      logic                  last;
   } tree_score_type;

   typedef struct {
      bit                    loaded;
      bit                    leaf;
      logic [FEAT_IDX_W-1:0] feature;
      logic [VALUE_W-1:0]    threshold;
      logic [VALUE_W-1:0]    value;
      logic [LEAF_ID_W-1:0]  leaf_id;
   } tree_node_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // predictor state
   tree_node_type          forest [NUM_TREES][NODE_SLOTS];
   logic [VALUE_W-1:0]     query_value [NUM_FEATURES];
   bit                     query_present [NUM_FEATURES];
   logic [TREES_CFG_W-1:0] trees_cfg = TREES_RESET;
   logic [DEPTH_CFG_W-1:0] depth_cfg = DEPTH_RESET;

   tree_score_type awaited_scores [$];
   int          mismatch_count = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   int          hold_request = 0;

   tree_ensemble_inference DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
   endtask

   function automatic int node_level(input int unsigned n);
      int lvl;
      lvl = 0;
      while (n > 1) begin
         n = n >> 1;
         lvl++;
      end
      return lvl;
   endfunction

   // Q16.16 values: mostly near zero so walks branch both ways, some extremes
   function automatic logic [VALUE_W-1:0] pick_q16();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
      endcase
   endfunction

   // small pool of features so splits and queries meet
   function automatic logic [FEAT_IDX_W-1:0] pick_feature();
      case ($urandom_range(0, 7))
         0: return 8'(NUM_FEATURES - 1);
         1: return 8'($urandom_range(0, NUM_FEATURES - 1));
         default: return 8'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [LEAF_ID_W-1:0] pick_leaf_id();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'd65534;
         default: return 16'($urandom_range(0, 65534));
      endcase
   endfunction

   // walk every tree in use, queue the per-tree results, clear presence
   task automatic score_query();
      int unsigned n_trees, lim, node, slot;
      longint total;
      logic [LEAF_ID_W-1:0] id;
      logic [VALUE_W-1:0] val;
      logic [FEAT_IDX_W-1:0] f;
      bit found, go_right;
      tree_score_type s;
      n_trees = trees_cfg;
      if (n_trees < 1) n_trees = 1;
      if (n_trees > NUM_TREES) n_trees = NUM_TREES;
      lim = (depth_cfg > DEEPEST_LEVEL) ? DEEPEST_LEVEL : depth_cfg;
      total = 0;
      for (int t = 0; t < n_trees; t++) begin
         node = 1;
         found = 1'b0;
         id = FAIL_ID;
         val = MINUS_ONE_Q16;
         for (int d = 0; d <= lim && !found; d++) begin
            slot = node & (NODE_SLOTS - 1);
            // stimulus must keep every reachable node loaded
            if (!forest[t][slot].loaded)
               flag_mismatch("walk reached an unloaded node", slot, t);
            if (forest[t][slot].leaf) begin
               id = forest[t][slot].leaf_id;
               val = forest[t][slot].value;
               found = 1'b1;
            end else begin
               f = forest[t][slot].feature;
               go_right = query_present[f] &&
                          !($signed(query_value[f]) < $signed(forest[t][slot].threshold));
               node = node * 2 + go_right;
            end
         end
         total += longint'($signed(val));
         if (total > SUM_MAX) total = SUM_MAX;
         if (total < SUM_MIN) total = SUM_MIN;
         s.tree = 4'(t);
         s.leaf_id = id;
         s.value = val;
         s.sum = total[SUM_W-1:0];
         s.last = (t + 1 == n_trees);
         awaited_scores.insert(awaited_scores.size(), s);
      end
      foreach (query_present[i]) query_present[i] = 1'b0;
   endtask

   // update the predictor with an accepted item
   task automatic absorb_item(input forest_item_type it);
      if (it.mode == MODE_NODE) begin
         forest[it.tree][it.node].loaded = 1'b1;
         forest[it.tree][it.node].leaf = it.is_leaf;
         if (it.is_leaf) begin
            forest[it.tree][it.node].value = it.leaf_value;
            forest[it.tree][it.node].leaf_id = it.leaf_id;
         end else begin
            forest[it.tree][it.node].feature = it.split_feature;
            forest[it.tree][it.node].threshold = it.split_threshold;
         end
      end else begin
         if (it.present) begin
            query_value[it.feature_index] = it.feature_value;
            query_present[it.feature_index] = 1'b1;
         end
         if (it.last) score_query();
      end
   endtask

   // present one item, with an occasional gap, and wait for its transfer
   task automatic offer_item(input forest_item_type it);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tlast <= it.last;
      req_tdata <= {1'b0, it.present, it.feature_value, it.feature_index, it.leaf_id,
                    it.leaf_value, it.split_threshold, it.split_feature, it.is_leaf,
                    it.node, it.tree};
      do @(posedge clock); while (req_tready !== 1'b1);
      absorb_item(it);
   endtask

   // fields that the item kind does not use carry random bits
   function automatic forest_item_type scrambled_item();
      forest_item_type it;
      it.mode = 1'($urandom());
      it.tree = 4'($urandom());
      it.node = 9'($urandom());
      it.is_leaf = 1'($urandom());
      it.split_feature = 8'($urandom());
      it.split_threshold = $urandom();
      it.leaf_value = $urandom();
      it.leaf_id = 16'($urandom());
      it.feature_index = 8'($urandom());
      it.feature_value = $urandom();
      it.present = 1'($urandom());
      it.last = 1'($urandom());
      return it;
   endfunction

   task automatic send_split(input int t, input int n, input logic [FEAT_IDX_W-1:0] f,
                             input logic [VALUE_W-1:0] thr);
      forest_item_type it;
      it = scrambled_item();
      it.mode = MODE_NODE;
      it.tree = 4'(t);
      it.node = 9'(n);
      it.is_leaf = 1'b0;
      it.split_feature = f;
      it.split_threshold = thr;
      offer_item(it);
   endtask

   task automatic send_leaf(input int t, input int n, input logic [VALUE_W-1:0] v,
                            input logic [LEAF_ID_W-1:0] id);
      forest_item_type it;
      it = scrambled_item();
      it.mode = MODE_NODE;
      it.tree = 4'(t);
      it.node = 9'(n);
      it.is_leaf = 1'b1;
      it.leaf_value = v;
      it.leaf_id = id;
      offer_item(it);
   endtask

   task automatic send_feature(input int idx, input logic [VALUE_W-1:0] v, input bit present,
                               input bit last);
      forest_item_type it;
      it = scrambled_item();
      it.mode = MODE_FEATURE;
      it.feature_index = 8'(idx);
      it.feature_value = v;
      it.present = present;
      it.last = last;
      offer_item(it);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_TREES_IN_USE) trees_cfg = val[TREES_CFG_W-1:0];
      else depth_cfg = val[DEPTH_CFG_W-1:0];
   endtask

   // drop valid, wait for every awaited result, then let queued loads drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // load a random tree in which every split above the deepest level has both
   // children loaded; the spine option forces a split down the left edge
   task automatic plant_tree(input int t, input bit spine);
      int unsigned pending [$];
      int unsigned n, lvl, count;
      bit make_split;
      pending.insert(0, 1);
      count = 0;
      while (pending.size() != 0) begin
         n = pending.pop_front();
         lvl = node_level(n);
         count++;
         if (spine && (n & (n - 1)) == 0) make_split = 1'b1;
         else if (count > 24) make_split = 1'b0;
         else if (lvl < DEEPEST_LEVEL) make_split = ($urandom_range(0, 1) == 0);
         else make_split = ($urandom_range(0, 2) == 0);
         if (make_split) begin
            send_split(t, n, pick_feature(), pick_q16());
            if (lvl < DEEPEST_LEVEL) begin
               pending.insert(pending.size(), 2 * n);
               pending.insert(pending.size(), 2 * n + 1);
            end
         end else begin
            send_leaf(t, n, pick_q16(), pick_leaf_id());
         end
      end
   endtask

   // random edits that keep every tree closed
   task automatic reshape_forest(input int changes);
      int t, n, lvl;
      repeat (changes) begin
         t = $urandom_range(0, NUM_TREES - 1);
         do n = $urandom_range(1, NODE_SLOTS - 1); while (!forest[t][n].loaded);
         lvl = node_level(n);
         case ($urandom_range(0, 3))
            // same kind, new contents
            0: begin
               if (forest[t][n].leaf) send_leaf(t, n, pick_q16(), pick_leaf_id());
               else send_split(t, n, pick_feature(), pick_q16());
            end
            // grow a leaf into a split; at the deepest level it has no children
            1: begin
               if (forest[t][n].leaf && lvl < DEEPEST_LEVEL) begin
                  send_leaf(t, 2 * n, pick_q16(), pick_leaf_id());
                  send_leaf(t, 2 * n + 1, pick_q16(), pick_leaf_id());
               end
               if (forest[t][n].leaf && lvl < DEEPEST_LEVEL || lvl == DEEPEST_LEVEL ||
                   !forest[t][n].leaf)
                  send_split(t, n, pick_feature(), pick_q16());
            end
            // prune to a leaf
            2: send_leaf(t, n, pick_q16(), pick_leaf_id());
            // slot zero is stored but never reached
            default: begin
               if ($urandom_range(0, 1) == 0) send_leaf(t, 0, pick_q16(), pick_leaf_id());
               else send_split(t, 0, pick_feature(), pick_q16());
            end
         endcase
      end
   endtask

   // a query: some feature writes, a few that write nothing, then the last one
   task automatic ask_forest(input int n_feats);
      repeat (n_feats) begin
         if ($urandom_range(0, 7) == 0)
            send_feature($urandom_range(0, NUM_FEATURES - 1), $urandom(), 1'b0, 1'b0);
         else
            send_feature(pick_feature(), pick_q16(), 1'b1, 1'b0);
      end
      send_feature(pick_feature(), pick_q16(), $urandom_range(0, 3) != 0, 1'b1);
   endtask

   task automatic test_directed_walks();
      write_csr(CSR_TREES_IN_USE, 5'd2);
      write_csr(CSR_DEPTH_LIMIT, 5'd8);
      send_split(0, 1, 8'd5, 32'h0000_0000);
      send_leaf(0, 2, 32'h7FFF_FFFF, 16'd65534);
      send_split(0, 3, 8'(NUM_FEATURES - 1), 32'h8000_0000);
      send_leaf(0, 6, 32'h8000_0000, 16'd0);
      send_leaf(0, 7, 32'h0001_0000, 16'd1);
      // a leaf holding -1.0, same value as a failed walk
      send_leaf(1, 1, MINUS_ONE_Q16, 16'h00AB);
      send_leaf(NUM_TREES - 1, 0, $urandom(), pick_leaf_id());
      // equal to threshold goes right; minimum threshold always passes
      send_feature(5, 32'h0000_0000, 1'b1, 1'b0);
      send_feature(NUM_FEATURES - 1, 32'hFFFF_FFFB, 1'b1, 1'b1);
      // empty query, everything absent
      send_feature(7, $urandom(), 1'b0, 1'b1);
      // below threshold goes left
      send_feature(5, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // second split tests an absent feature
      send_feature(5, 32'd7, 1'b1, 1'b0);
      send_feature(9, $urandom(), 1'b0, 1'b0);
      send_feature(0, $urandom(), 1'b0, 1'b1);
      send_feature(5, 32'h7FFF_FFFF, 1'b1, 1'b0);
      send_feature(NUM_FEATURES - 1, 32'h8000_0000, 1'b1, 1'b1);
      settle();
      // root split with no levels left fails the walk
      write_csr(CSR_DEPTH_LIMIT, 5'd0);
      send_feature(5, 32'h0001_0000, 1'b1, 1'b1);
      settle();
   endtask

   task automatic test_forest_build();
      write_csr(CSR_TREES_IN_USE, 5'd16);
      write_csr(CSR_DEPTH_LIMIT, 5'd8);
      for (int t = 0; t < NUM_TREES; t++) plant_tree(t, t == 0);
      repeat (4) ask_forest($urandom_range(0, 5));
      // all absent: tree 0 runs down its spine and fails
      send_feature(3, $urandom(), 1'b0, 1'b1);
      settle();
   endtask

   task automatic test_config_sweep();
      logic [CSR_DATA_W-1:0] trees, depth;
      for (int i = 0; i < 8; i++) begin
         case (i)
            0: begin trees = 5'd1;  depth = 5'd0;  end
            1: begin trees = 5'd16; depth = 5'd0;  end
            2: begin trees = 5'd1;  depth = 5'd8;  end
            3: begin trees = 5'd16; depth = 5'd8;  end
            // out of range: 0 trees acts as one, 31 as sixteen; depth 15 clipped, 0x13 cut to 3
            4: begin trees = 5'd0;  depth = 5'd15; end
            5: begin trees = 5'd31; depth = 5'h13; end
            default: begin
               trees = 5'($urandom_range(1, 16));
               depth = 5'($urandom_range(0, 8));
            end
         endcase
         settle();
         write_csr(CSR_TREES_IN_USE, trees);
         write_csr(CSR_DEPTH_LIMIT, depth);
         repeat (3) begin
            reshape_forest($urandom_range(0, 2));
            ask_forest($urandom_range(0, 5));
         end
      end
      settle();
   endtask

   task automatic test_tree_updates();
      write_csr(CSR_TREES_IN_USE, 5'd16);
      write_csr(CSR_DEPTH_LIMIT, 5'($urandom_range(4, 8)));
      repeat (6) begin
         reshape_forest($urandom_range(1, 3));
         ask_forest($urandom_range(1, 5));
      end
      settle();
   endtask

   // receiver holds off while queries keep coming: input must stall
   task automatic test_result_backpressure();
      sender_gaps = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (3) ask_forest(2);
      settle();
      sender_gaps = 1'b1;
   endtask

   task automatic test_full_rate();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      repeat (6) begin
         reshape_forest(1);
         ask_forest($urandom_range(0, 4));
      end
   endtask

   // result side ready: random stalls, or one long hold when asked
   initial begin : rsp_ready_driver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest awaited score
   initial begin : result_checker
      tree_score_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (awaited_scores.size() == 0) begin
               flag_mismatch("result with nothing awaited", rsp_tdata[63:0], 64'd0);
            end else begin
               want = awaited_scores.pop_front();
               if (rsp_tdata[3:0] !== want.tree)
                  flag_mismatch("tree_index", rsp_tdata[3:0], want.tree);
               if (rsp_tdata[19:4] !== want.leaf_id)
                  flag_mismatch("reached_leaf", rsp_tdata[19:4], want.leaf_id);
               if (rsp_tdata[51:20] !== want.value)
                  flag_mismatch("tree_value", rsp_tdata[51:20], want.value);
               if (rsp_tdata[87:52] !== want.sum)
                  flag_mismatch("forest_sum", rsp_tdata[87:52], want.sum);
               if (rsp_tlast !== want.last)
                  flag_mismatch("last_result", rsp_tlast, want.last);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_walks();
      test_forest_build();
      test_config_sweep();
      test_tree_updates();
      test_result_backpressure();
      test_full_rate();
      settle();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tei_pkg.sv
hdl/tei_front.sv
hdl/tei_queue.sv
hdl/tei_back.sv
hdl/tree_ensemble_inference.sv
hdl/tei_checker.sv
bench/testbench.sv
